// ----- rtl/core/quadrature_nco_macros.svh -----
// Assertion macros used by the quadrature oscillator port checks.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef QUADRATURE_NCO_MACROS_SVH
`define QUADRATURE_NCO_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define QNCO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadrature_nco check failed");

// Consequent checked in the cycle after the antecedent.
`define QNCO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadrature_nco check failed");

`endif

// ----- rtl/core/qnco_pkg.sv -----
// Package for the quadrature oscillator: widths, command codes, CORDIC constants.
// Used by every module in rtl/core; depends on nothing.
package qnco_pkg;

	localparam int PHASE_BITS    = 32;
	localparam int OUT_BITS      = 16;
	localparam int SINCOS_STAGES = 16;

	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_N     = (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;
	localparam int IDX_W        = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

	localparam int XY_W = 34;
	localparam int Z_W  = 34;

	localparam int SH_UP  = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
	localparam int SH_DN  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
	localparam int RND_SH = 31 - OUT_BITS;

	typedef logic [63:0] wide_t;

	typedef enum logic [2:0] {
		CMD_STEP      = 3'd0,
		CMD_PEEK      = 3'd1,
		CMD_SET_PHASE = 3'd2,
		CMD_SET_FREQ  = 3'd3,
		CMD_ADD_FREQ  = 3'd4
	} cmd_t;

	localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032875);
	localparam logic signed [XY_W-1:0] RND_HALF  = XY_W'(64'd1 << (RND_SH - 1));
	localparam logic signed [XY_W-1:0] OUT_MAX   = XY_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
	localparam logic signed [XY_W-1:0] OUT_MIN   = -OUT_MAX - XY_W'(1);

	localparam logic [29:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
		30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
		30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

	typedef struct packed {
		logic                   neg;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cord_t;

	function automatic logic signed [Z_W-1:0] atan_at(input int k);
		return Z_W'(ATAN_TURNS[k]);
	endfunction

	function automatic logic [IDX_W-1:0] idx_at(input int k);
		return IDX_W'(k);
	endfunction

	function automatic logic [31:0] top32(input logic [PHASE_BITS-1:0] acc);
		wide_t w;
		w = wide_t'(acc);
		return 32'((w << SH_DN) >> SH_UP);
	endfunction

	function automatic logic [PHASE_BITS-1:0] align_in(input wide_t v);
		return PHASE_BITS'((v << SH_UP) >> SH_DN);
	endfunction

endpackage

// ----- rtl/core/qnco_phase.sv -----
// Phase and frequency registers, command decode and quadrant fold into the first cell.
// Depends on qnco_pkg.
module qnco_phase (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic [2:0]             command,
	input  logic [31:0]            phase_value,
	input  logic signed [31:0]     freq_value,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output qnco_pkg::cord_t        dn_data
);

	logic [qnco_pkg::PHASE_BITS-1:0] phase_q;
	logic [qnco_pkg::PHASE_BITS-1:0] freq_q;
	logic                            vld_s1;
	qnco_pkg::cord_t                 ent_s1;
	qnco_pkg::cord_t                 ent_nxt;
	logic                            ready;
	logic                            take;
	logic [31:0]                     ang;
	logic [31:0]                     ang_f;
	logic                            fold;
	logic [qnco_pkg::PHASE_BITS-1:0] ph_al;
	logic [qnco_pkg::PHASE_BITS-1:0] fr_al;

	assign ready     = !vld_s1 || dn_ready;
	assign cmd_stall = !ready;
	assign take      = cmd_valid && ready;
	assign dn_valid  = vld_s1;
	assign dn_data   = ent_s1;

	assign ph_al = qnco_pkg::align_in(qnco_pkg::wide_t'(phase_value));
	assign fr_al = qnco_pkg::align_in({{32{freq_value[31]}}, freq_value});

	// fold quadrants 1 and 2 by half a turn
	always_comb begin
		ang           = qnco_pkg::top32(phase_q);
		fold          = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
		ang_f         = {ang[31] ^ fold, ang[30:0]};
		ent_nxt.neg   = fold;
		ent_nxt.x     = qnco_pkg::CORDIC_X0;
		ent_nxt.y     = '0;
		ent_nxt.z     = {{(qnco_pkg::Z_W-32){ang_f[31]}}, ang_f};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			freq_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (ready) begin
				vld_s1 <= cmd_valid;
			end
			if (take) begin
				case (command)
					qnco_pkg::CMD_STEP:      phase_q <= phase_q + freq_q;
					qnco_pkg::CMD_PEEK:      phase_q <= phase_q;
					qnco_pkg::CMD_SET_PHASE: phase_q <= ph_al;
					qnco_pkg::CMD_SET_FREQ:  freq_q  <= fr_al;
					qnco_pkg::CMD_ADD_FREQ:  freq_q  <= freq_q + fr_al;
					default:                 phase_q <= phase_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= ent_nxt;
		end
	end

endmodule

// ----- rtl/core/qnco_cell.sv -----
// One CORDIC rotation cell with its own valid/ready slot.
// Depends on qnco_pkg; stage index and arctangent come in as tied-off inputs.
module qnco_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [qnco_pkg::IDX_W-1:0]       stage,
	input  logic signed [qnco_pkg::Z_W-1:0]  atan,
	input  logic                             up_valid,
	output logic                             up_ready,
	input  qnco_pkg::cord_t                  up_data,
	output logic                             dn_valid,
	input  logic                             dn_ready,
	output qnco_pkg::cord_t                  dn_data
);

	logic                              vld_q;
	qnco_pkg::cord_t                   cord_q;
	qnco_pkg::cord_t                   nxt;
	logic signed [qnco_pkg::XY_W-1:0]  xi;
	logic signed [qnco_pkg::XY_W-1:0]  yi;
	logic signed [qnco_pkg::XY_W-1:0]  x_sh;
	logic signed [qnco_pkg::XY_W-1:0]  y_sh;

	assign up_ready = !vld_q || dn_ready;
	assign dn_valid = vld_q;
	assign dn_data  = cord_q;

	always_comb begin
		xi      = up_data.x;
		yi      = up_data.y;
		x_sh    = xi >>> stage;
		y_sh    = yi >>> stage;
		nxt.neg = up_data.neg;
		if (!up_data.z[qnco_pkg::Z_W-1]) begin
			nxt.x = xi - y_sh;
			nxt.y = yi + x_sh;
			nxt.z = up_data.z - atan;
		end else begin
			nxt.x = xi + y_sh;
			nxt.y = yi - x_sh;
			nxt.z = up_data.z + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			cord_q <= nxt;
		end
	end

endmodule

// ----- rtl/core/qnco_out.sv -----
// Output stage: round to the output width, undo the fold, saturate, hold the result item.
// Depends on qnco_pkg.
module qnco_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  qnco_pkg::cord_t                     up_data,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [qnco_pkg::OUT_BITS-1:0] cos_out,
	output logic signed [qnco_pkg::OUT_BITS-1:0] sin_out
);

	logic                                 vld_q;
	logic signed [qnco_pkg::OUT_BITS-1:0] cos_q;
	logic signed [qnco_pkg::OUT_BITS-1:0] sin_q;
	logic signed [qnco_pkg::XY_W-1:0]     xr;
	logic signed [qnco_pkg::XY_W-1:0]     yr;
	logic signed [qnco_pkg::XY_W-1:0]     xs;
	logic signed [qnco_pkg::XY_W-1:0]     ys;

	assign up_ready  = !vld_q || !res_stall;
	assign res_valid = vld_q;
	assign cos_out   = cos_q;
	assign sin_out   = sin_q;

	always_comb begin
		xr = (up_data.x + qnco_pkg::RND_HALF) >>> qnco_pkg::RND_SH;
		yr = (up_data.y + qnco_pkg::RND_HALF) >>> qnco_pkg::RND_SH;
		if (up_data.neg) begin
			xr = -xr;
			yr = -yr;
		end
		xs = xr;
		ys = yr;
		if (xr > qnco_pkg::OUT_MAX) begin
			xs = qnco_pkg::OUT_MAX;
		end else if (xr < qnco_pkg::OUT_MIN) begin
			xs = qnco_pkg::OUT_MIN;
		end
		if (yr > qnco_pkg::OUT_MAX) begin
			ys = qnco_pkg::OUT_MAX;
		end else if (yr < qnco_pkg::OUT_MIN) begin
			ys = qnco_pkg::OUT_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			cos_q <= qnco_pkg::OUT_BITS'(xs);
			sin_q <= qnco_pkg::OUT_BITS'(ys);
		end
	end

endmodule

// ----- rtl/core/quadrature_nco.sv -----
// Quadrature oscillator top level: phase/frequency front end, row of CORDIC cells, output stage.
// Depends on qnco_pkg, qnco_phase, qnco_cell and qnco_out.
//
// Command channel (cmd_valid/cmd_stall) carries command, phase_value and freq_value.
// Result channel (res_valid/res_stall) carries cos_out and sin_out, Q1.15, +1 shown as 32767.
// Each item yields one result: cosine and sine of the phase held before the item.
// A step then adds the frequency to the phase; set phase, set frequency and add to
// frequency load or adjust the registers; peek and unused codes change nothing.
// Throughput: one item per clock while cmd_stall is low; the phase update is a single add done on acceptance.
// From acceptance to res_valid: one fold stage, one cell per CORDIC rotation, one rounding stage.
// Every stage holds its own item, so a stalled receiver freezes only the full part of
// the row; cmd_stall rises once every stage holds an item and res_stall is high.
// Reset clears phase and frequency to zero and empties the row; no result is pending.
module quadrature_nco (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic [2:0]                           command,
	input  logic [31:0]                          phase_value,
	input  logic signed [31:0]                   freq_value,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [qnco_pkg::OUT_BITS-1:0] cos_out,
	output logic signed [qnco_pkg::OUT_BITS-1:0] sin_out
);

	logic            vld   [qnco_pkg::CORDIC_N+1];
	logic            rdy   [qnco_pkg::CORDIC_N+1];
	qnco_pkg::cord_t chain [qnco_pkg::CORDIC_N+1];

	qnco_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.phase_value (phase_value),
		.freq_value  (freq_value),
		.dn_valid    (vld[0]),
		.dn_ready    (rdy[0]),
		.dn_data     (chain[0])
	);

	for (genvar k = 0; k < qnco_pkg::CORDIC_N; k++) begin : g_cell
		qnco_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage    (qnco_pkg::idx_at(k)),
			.atan     (qnco_pkg::atan_at(k)),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up_data  (chain[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_data  (chain[k+1])
		);
	end

	qnco_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (vld[qnco_pkg::CORDIC_N]),
		.up_ready  (rdy[qnco_pkg::CORDIC_N]),
		.up_data   (chain[qnco_pkg::CORDIC_N]),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cos_out   (cos_out),
		.sin_out   (sin_out)
	);

endmodule

// ----- rtl/core/qnco_checker.sv -----
// Port-level checks for the quadrature oscillator, bound to quadrature_nco.
// Depends on qnco_pkg and quadrature_nco_macros.svh.
`include "quadrature_nco_macros.svh"

module qnco_props (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cmd_stall,
	input logic                                 res_valid,
	input logic                                 res_stall,
	input logic signed [qnco_pkg::OUT_BITS-1:0] cos_out,
	input logic signed [qnco_pkg::OUT_BITS-1:0] sin_out
);

	`QNCO_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`QNCO_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(cos_out) && $stable(sin_out))
	`QNCO_ASSERT_SAME(a_room_when_empty, !res_valid, !cmd_stall)
	`QNCO_ASSERT_SAME(a_unit_circle, res_valid, !(cos_out == '0 && sin_out == '0))

endmodule

bind quadrature_nco qnco_props u_chk (.*);

// ----- bench/qnco_checker.sv -----
`timescale 1ns / 100ps
// Checker for the quadrature oscillator: predicts cosine and sine per command item.
// Watches both channels of quadrature_nco and depends on qnco_pkg for widths and codes.
module qnco_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  logic                                 cmd_stall,
	input  logic [2:0]                           command,
	input  logic [31:0]                          phase_value,
	input  logic signed [31:0]                   freq_value,
	input  logic                                 res_valid,
	input  logic                                 res_stall,
	input  logic signed [qnco_pkg::OUT_BITS-1:0] cos_out,
	input  logic signed [qnco_pkg::OUT_BITS-1:0] sin_out,
	input  logic                                 drain_done,
	output int                                   fault_count,
	output int                                   pending
);
	import qnco_pkg::*;

	localparam int PB      = PHASE_BITS;
	localparam int OB      = OUT_BITS;
	localparam int UP      = (PB > 32) ? PB - 32 : 0;
	localparam int DN      = (PB < 32) ? 32 - PB : 0;
	localparam int N_ROT   = (SINCOS_STAGES < 24) ? SINCOS_STAGES : 24;
	localparam int RSH     = 31 - OB;
	localparam longint X_START = 652032875;
	localparam longint ATAN_TAB [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct {
		logic signed [OB-1:0] cos_v;
		logic signed [OB-1:0] sin_v;
	} quad_sample_t;

	quad_sample_t      sample_q[$];
	logic [PB-1:0]     phase_q;
	logic [PB-1:0]     freq_q;
	logic              leftovers_seen;

	function automatic longint clamp_out(input longint v);
		longint hi;
		hi = (longint'(1) << (OB - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic quad_sample_t trig_of(input logic [PB-1:0] acc);
		logic [31:0]  a;
		logic         folded;
		longint       x, y, z, nx;
		quad_sample_t r;
		a = 32'((64'(acc) << DN) >> UP);
		folded = a[31] ^ a[30];
		if (folded)
			a[31] = ~a[31];
		z = longint'($signed(a));
		x = X_START;
		y = 0;
		for (int k = 0; k < N_ROT; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				y  = y + (x >>> k);
				z  = z - ATAN_TAB[k];
			end else begin
				nx = x + (y >>> k);
				y  = y - (x >>> k);
				z  = z + ATAN_TAB[k];
			end
			x = nx;
		end
		x = (x + (longint'(1) << (RSH - 1))) >>> RSH;
		y = (y + (longint'(1) << (RSH - 1))) >>> RSH;
		if (folded) begin
			x = -x;
			y = -y;
		end
		r.cos_v = OB'(clamp_out(x));
		r.sin_v = OB'(clamp_out(y));
		return r;
	endfunction

	function automatic logic [PB-1:0] to_acc(input logic [63:0] v);
		return PB'((v << UP) >> DN);
	endfunction

	task automatic report_fault(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		quad_sample_t want;
		if (!arst_n) begin
			phase_q        = '0;
			freq_q         = '0;
			sample_q       = {};
			pending        = 0;
			fault_count    = 0;
			leftovers_seen = 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (sample_q.size() == 0) begin
					report_fault($sformatf("result %0d/%0d with nothing expected",
						cos_out, sin_out));
				end else begin
					want = sample_q.pop_front();
					if (cos_out !== want.cos_v)
						report_fault($sformatf("cos_out %0d, predicted %0d",
							cos_out, want.cos_v));
					if (sin_out !== want.sin_v)
						report_fault($sformatf("sin_out %0d, predicted %0d",
							sin_out, want.sin_v));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				sample_q.push_back(trig_of(phase_q));
				case (command)
					CMD_STEP:      phase_q = phase_q + freq_q;
					CMD_SET_PHASE: phase_q = to_acc(64'(phase_value));
					CMD_SET_FREQ:  freq_q  = to_acc(64'(longint'(freq_value)));
					CMD_ADD_FREQ:  freq_q  = freq_q + to_acc(64'(longint'(freq_value)));
					default: ;
				endcase
			end
			pending = sample_q.size();
			if (drain_done && !leftovers_seen && pending != 0) begin
				leftovers_seen = 1'b1;
				report_fault($sformatf("%0d results never arrived", pending));
			end
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Top of the quadrature oscillator bench: clock, reset, command items and result stalls.
// Instantiates quadrature_nco beside qnco_checker and depends on qnco_pkg.
module testbench;
	import qnco_pkg::*;

	localparam int         RESET_CYCLES = 6;
	localparam int         ITEMS_A      = 170;
	localparam int         ITEMS_B      = 170;
	localparam int         ITEMS_C      = 160;
	localparam int         LONG_HOLD    = 64;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_MD = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic                       clk;
	logic                       arst_n;
	logic                       cmd_valid;
	logic                       cmd_stall;
	logic [2:0]                 command;
	logic [31:0]                phase_value;
	logic signed [31:0]         freq_value;
	logic                       res_valid;
	logic                       res_stall;
	logic signed [OUT_BITS-1:0] cos_out;
	logic signed [OUT_BITS-1:0] sin_out;
	logic                       drain_done;
	logic                       hold_due;
	int                         fault_count;
	int                         pending;
	int                         send_pct;
	int                         recv_pct;
	int                         cycle_count;

	quadrature_nco u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.phase_value (phase_value),
		.freq_value  (freq_value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.cos_out     (cos_out),
		.sin_out     (sin_out)
	);

	qnco_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.phase_value (phase_value),
		.freq_value  (freq_value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.cos_out     (cos_out),
		.sin_out     (sin_out),
		.drain_done  (drain_done),
		.fault_count (fault_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		cycle_count = 0;
		forever @(posedge clk) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// hold the result side off for a long stretch once asked, else stall at random
	initial begin
		int hold_left;
		logic hold_done;
		res_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever @(negedge clk) begin
			if (hold_due && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < recv_pct);
			end
		end
	end

	task automatic send_item(input logic [2:0] c, input logic [31:0] p, input logic [31:0] f);
		while ($urandom_range(0, 99) < send_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid   <= 1'b1;
		command     <= c;
		phase_value <= p;
		freq_value  <= f;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0]  c;
		logic [31:0] p;
		logic [31:0] f;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 45)
			c = CMD_STEP;
		else if (r < 54)
			c = CMD_PEEK;
		else if (r < 67)
			c = CMD_SET_PHASE;
		else if (r < 79)
			c = CMD_SET_FREQ;
		else if (r < 94)
			c = CMD_ADD_FREQ;
		else
			c = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		case ($urandom_range(0, 3))
			0: p = $urandom;
			1: p = {2'($urandom_range(0, 3)), 30'($urandom_range(0, 15))};
			2: p = {2'($urandom_range(0, 3)), 30'h3FFF_FFFF - 30'($urandom_range(0, 15))};
			default: p = $urandom;
		endcase
		case ($urandom_range(0, 4))
			0: f = 32'($urandom_range(0, 65535));
			1: f = -32'($urandom_range(0, 65535));
			2: f = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: f = $urandom;
		endcase
		send_item(c, p, f);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		command     = CMD_PEEK;
		phase_value = '0;
		freq_value  = '0;
		drain_done  = 1'b0;
		hold_due    = 1'b0;
		send_pct    = 20;
		recv_pct    = 79;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(CMD_PEEK,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_STEP,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_SET_PHASE, 32'h4000_0000, 32'h0000_0000);
		send_item(CMD_SET_PHASE, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(CMD_SET_PHASE, 32'hC000_0000, 32'h0000_0000);
		send_item(CMD_SET_PHASE, 32'h3FFF_FFFF, 32'h0000_0000);
		send_item(CMD_SET_PHASE, 32'hBFFF_FFFF, 32'h0000_0000);
		send_item(CMD_SET_PHASE, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(CMD_SET_FREQ,  32'h0000_0000, 32'h7FFF_FFFF);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_SET_FREQ,  32'hFFFF_FFFF, 32'h8000_0000);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_ADD_FREQ,  32'h0000_0000, 32'hFFFF_FFFF);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_ADD_FREQ,  32'h0000_0000, 32'h0000_0001);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_SPARE_LO,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_SPARE_MD,  32'h5555_5555, 32'hAAAA_AAAA);
		send_item(CMD_SPARE_HI,  32'hAAAA_AAAA, 32'h5555_5555);
		send_item(CMD_SET_FREQ,  32'h0000_0000, 32'h1000_0000);
		send_item(CMD_STEP,      32'h0000_0000, 32'h0000_0000);
		send_item(CMD_PEEK,      32'h0000_0000, 32'h0000_0000);

		repeat (ITEMS_A) send_random();

		wait_idle();
		send_pct = 79;
		recv_pct <= 20;
		repeat (ITEMS_B) send_random();

		send_pct = 0;
		recv_pct <= 0;
		hold_due <= 1'b1;
		repeat (ITEMS_C) send_random();

		wait_idle();
		repeat (SINCOS_STAGES + 8) @(negedge clk);
		drain_done <= 1'b1;
		repeat (2) @(negedge clk);
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
